/* rtl/lwba_pkg.sv */
`default_nettype none

package lwba_pkg;

    // field widths
    localparam int NOW_W      = 32;
    localparam int LOSS_W     = 14;
    localparam int JIT_W      = 16;
    localparam int CODE_W     = 18;
    localparam int KBPS_W     = 16;
    localparam int MS14_W     = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // stream word layout
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;

    // weighting and rate arithmetic
    localparam int W_W        = 14;
    localparam int PROD_W     = LOSS_W + W_W;
    localparam int MUL_W      = 14;
    localparam int DIVIDEND_W = KBPS_W + MUL_W;
    localparam int QUOT_W     = 17;

    // x / (2^pre * d) = ((x >> pre) * ceil(2^k / d)) >> k, exact over the
    // dividend range; 15000 = 8 * 1875 and 100 = 4 * 25
    localparam int RCP_Y_W        = DIVIDEND_W - 3;
    localparam int RCP_M_W        = 28;
    localparam int CUT_PRE_SHIFT  = 3;
    localparam int CUT_RCP_SHIFT  = 38;
    localparam int REMB_PRE_SHIFT = 2;
    localparam int REMB_RCP_SHIFT = 26;
    localparam logic [RCP_M_W-1:0] CUT_RCP  = 28'd146601551;
    localparam logic [RCP_M_W-1:0] REMB_RCP = 28'd2684355;
    localparam logic [RCP_M_W-1:0] UNIT_RCP = 28'd1;

    localparam logic [CODE_W-1:0] REMB_DEC_CODE = 18'h06803;
    localparam logic [CODE_W-1:0] REMB_INC_CODE = 18'h07378;

    localparam logic [W_W-1:0]   W_ZERO_LOSS = 14'd2000;
    localparam logic [W_W-1:0]   W_FULL      = 14'd10000;
    localparam logic [MUL_W-1:0] CUT_SCALE   = 14'd15000;
    localparam logic [MUL_W-1:0] REMB_DN_MUL = 14'd85;
    localparam logic [MUL_W-1:0] REMB_UP_MUL = 14'd105;
    localparam logic [MUL_W-1:0] REMB_DIV    = 14'd100;
    localparam logic [MUL_W-1:0] UNIT_MUL    = 14'd1;

    // register reset values
    localparam logic [KBPS_W-1:0] MIN_KBPS_RST     = 16'd100;
    localparam logic [KBPS_W-1:0] MAX_KBPS_RST     = 16'd4000;
    localparam logic [KBPS_W-1:0] START_KBPS_RST   = 16'd800;
    localparam logic [15:0]       HOLD_MS_RST      = 16'd1000;
    localparam logic [15:0]       FILL_MS_RST      = 16'd1000;
    localparam logic [MS14_W-1:0] EXPIRY_MS_RST    = 14'd2000;
    localparam logic [MS14_W-1:0] LOSS_TRIGGER_RST = 14'd500;
    localparam logic [JIT_W-1:0]  JITTER_LIMIT_RST = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_KBPS,
        REG_MAX_KBPS,
        REG_START_KBPS,
        REG_HOLD_MS,
        REG_FILL_MS,
        REG_EXPIRY_MS,
        REG_LOSS_TRIGGER,
        REG_JITTER_LIMIT
    } t_reg_idx;

    typedef enum logic [1:0] {
        CAUSE_CLAMP,
        CAUSE_LOSS_CUT,
        CAUSE_REMB_DN,
        CAUSE_REMB_UP
    } t_cause;

    typedef struct packed {
        logic [KBPS_W-1:0] min_kbps;
        logic [KBPS_W-1:0] max_kbps;
        logic [KBPS_W-1:0] start_kbps;
        logic [15:0]       hold_ms;
        logic [15:0]       fill_ms;
        logic [MS14_W-1:0] expiry_ms;
        logic [MS14_W-1:0] loss_trigger;
        logic [JIT_W-1:0]  jitter_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic   load;
        logic   walk_start;
        logic   walk_end;
        logic   div_start;
        t_cause div_sel;
        logic   cut_commit;
        logic   emit;
    } t_cmd;

    typedef struct packed {
        logic is_remb;
        logic remb_hit;
        logic remb_up;
        logic ignore;
        logic walk_done;
        logic in_fill;
        logic cut;
        logic div_busy;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/lwba_cfg.sv */
`default_nettype none

module lwba_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [lwba_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [lwba_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output lwba_pkg::t_cfg                        o_cfg,
    output logic                                  o_start_load
);

    lwba_pkg::t_cfg r_cfg;
    logic           r_start_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_kbps        <= lwba_pkg::MIN_KBPS_RST;
            r_cfg.max_kbps        <= lwba_pkg::MAX_KBPS_RST;
            r_cfg.start_kbps      <= lwba_pkg::START_KBPS_RST;
            r_cfg.hold_ms         <= lwba_pkg::HOLD_MS_RST;
            r_cfg.fill_ms         <= lwba_pkg::FILL_MS_RST;
            r_cfg.expiry_ms       <= lwba_pkg::EXPIRY_MS_RST;
            r_cfg.loss_trigger    <= lwba_pkg::LOSS_TRIGGER_RST;
            r_cfg.jitter_limit_ms <= lwba_pkg::JITTER_LIMIT_RST;
            r_start_load          <= 1'b0;
        end else begin
            r_start_load <= 1'b0;
            if (i_cfg_we) begin
                unique case (lwba_pkg::t_reg_idx'(i_cfg_idx))
                    lwba_pkg::REG_MIN_KBPS:     r_cfg.min_kbps <= i_cfg_data;
                    lwba_pkg::REG_MAX_KBPS:     r_cfg.max_kbps <= i_cfg_data;
                    lwba_pkg::REG_START_KBPS: begin
                        r_cfg.start_kbps <= i_cfg_data;
                        r_start_load     <= 1'b1;
                    end
                    lwba_pkg::REG_HOLD_MS:      r_cfg.hold_ms <= i_cfg_data;
                    lwba_pkg::REG_FILL_MS:      r_cfg.fill_ms <= i_cfg_data;
                    lwba_pkg::REG_EXPIRY_MS:
                        r_cfg.expiry_ms <= i_cfg_data[lwba_pkg::MS14_W-1:0];
                    lwba_pkg::REG_LOSS_TRIGGER:
                        r_cfg.loss_trigger <= i_cfg_data[lwba_pkg::MS14_W-1:0];
                    lwba_pkg::REG_JITTER_LIMIT: r_cfg.jitter_limit_ms <= i_cfg_data;
                endcase
            end
        end
    end

    assign o_cfg        = r_cfg;
    assign o_start_load = r_start_load;

endmodule

`default_nettype wire

/* rtl/lwba_div.sv */
`default_nettype none

// Divide by one of the fixed rate divisors: pre-shift by the power-of-two
// part, multiply by the rounded-up reciprocal, shift down. The product is
// registered from the registered operands; the quotient is valid once busy drops.
module lwba_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [lwba_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  wire lwba_pkg::t_cause                  i_sel,
    output logic                                   o_busy,
    output logic [lwba_pkg::QUOT_W-1:0]            o_quot
);

    localparam int YW = lwba_pkg::RCP_Y_W;
    localparam int MW = lwba_pkg::RCP_M_W;
    localparam int PW = YW + MW;
    localparam int QW = lwba_pkg::QUOT_W;

    logic                 r_busy;
    lwba_pkg::t_cause     r_sel;
    logic [YW-1:0]        r_y;
    logic [MW-1:0]        r_m;
    logic [PW-1:0]        r_prod;

    logic [YW-1:0]        y;
    logic [MW-1:0]        m;

    always_comb begin
        unique case (i_sel)
            lwba_pkg::CAUSE_CLAMP: begin
                y = YW'(i_dividend);
                m = lwba_pkg::UNIT_RCP;
            end
            lwba_pkg::CAUSE_LOSS_CUT: begin
                y = YW'(i_dividend >> lwba_pkg::CUT_PRE_SHIFT);
                m = lwba_pkg::CUT_RCP;
            end
            lwba_pkg::CAUSE_REMB_DN, lwba_pkg::CAUSE_REMB_UP: begin
                y = YW'(i_dividend >> lwba_pkg::REMB_PRE_SHIFT);
                m = lwba_pkg::REMB_RCP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sel  <= lwba_pkg::CAUSE_CLAMP;
        end else begin
            r_busy <= i_start;
            if (i_start) begin
                r_sel <= i_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_y <= y;
            r_m <= m;
        end
        if (r_busy) begin
            r_prod <= PW'(r_y) * PW'(r_m);
        end
    end

    always_comb begin
        unique case (r_sel)
            lwba_pkg::CAUSE_CLAMP:    o_quot = r_prod[QW-1:0];
            lwba_pkg::CAUSE_LOSS_CUT: o_quot = r_prod[lwba_pkg::CUT_RCP_SHIFT +: QW];
            lwba_pkg::CAUSE_REMB_DN,
            lwba_pkg::CAUSE_REMB_UP:  o_quot = r_prod[lwba_pkg::REMB_RCP_SHIFT +: QW];
        endcase
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

/* rtl/lwba_ctrl.sv */
`default_nettype none

module lwba_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_tvalid,
    output logic                o_tready,
    input  wire lwba_pkg::t_stat i_stat,
    output lwba_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WALK,
        ST_EVAL,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_tvalid) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    priority if (i_stat.is_remb) begin
                        r_state <= i_stat.remb_hit ? ST_DIV : ST_IDLE;
                    end else if (i_stat.ignore) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (i_stat.walk_done) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_state <= i_stat.in_fill ? ST_IDLE : ST_DIV;
                end
                ST_DIV: begin
                    if (!i_stat.div_busy) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!i_stat.out_busy) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE:   o_cmd.load = i_tvalid;
            ST_DECIDE: begin
                if (i_stat.is_remb) begin
                    o_cmd.div_start = i_stat.remb_hit;
                    o_cmd.div_sel   = i_stat.remb_up ? lwba_pkg::CAUSE_REMB_UP
                                                     : lwba_pkg::CAUSE_REMB_DN;
                end else begin
                    o_cmd.walk_start = !i_stat.ignore;
                end
            end
            ST_WALK:   o_cmd.walk_end = i_stat.walk_done;
            ST_EVAL: begin
                o_cmd.div_start  = !i_stat.in_fill;
                o_cmd.cut_commit = !i_stat.in_fill && i_stat.cut;
                o_cmd.div_sel    = i_stat.cut ? lwba_pkg::CAUSE_LOSS_CUT
                                              : lwba_pkg::CAUSE_CLAMP;
            end
            ST_DIV:    o_cmd.emit = 1'b0;
            ST_EMIT:   o_cmd.emit = !i_stat.out_busy;
            default:   o_cmd = '0;
        endcase
    end

    assign o_tready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

/* rtl/lwba_dp.sv */
`default_nettype none

module lwba_dp #(
    parameter int HISTORY_DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire lwba_pkg::t_cfg                    i_cfg,
    input  wire logic                              i_start_load,
    input  wire lwba_pkg::t_cmd                    i_cmd,
    output lwba_pkg::t_stat                        o_stat,
    input  wire logic [lwba_pkg::IN_DATA_W-1:0]    i_tdata,
    input  wire logic                              i_tuser,
    output logic                                   o_tvalid,
    input  wire logic                              i_tready,
    output logic [lwba_pkg::OUT_DATA_W-1:0]        o_tdata,
    output logic [1:0]                             o_tuser
);

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int NUM_W  = lwba_pkg::PROD_W + $clog2(HISTORY_DEPTH);
    localparam int DEN_W  = lwba_pkg::W_W + $clog2(HISTORY_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);

    localparam int NW = lwba_pkg::NOW_W;
    localparam int LW = lwba_pkg::LOSS_W;
    localparam int KW = lwba_pkg::KBPS_W;

    typedef struct packed {
        logic [NW-1:0] stamp;
        logic [LW-1:0] loss;
    } t_entry;

    // history store
    t_entry mem [HISTORY_DEPTH];

    // current item
    logic                          r_mode;
    logic [NW-1:0]                 r_now;
    logic [LW-1:0]                 r_loss;
    logic [lwba_pkg::JIT_W-1:0]    r_jitter;
    logic [lwba_pkg::CODE_W-1:0]   r_code;

    // block state
    logic [KW-1:0]                 r_cur;
    logic [NW-1:0]                 r_restart;
    logic [CNT_W-1:0]              r_count;

    // history walk
    logic                          r_issue;
    logic [CNT_W-1:0]              r_rd_ptr;
    logic [CNT_W-1:0]              r_wr_ptr;
    logic                          r_p1_v;
    logic                          r_p1_new;
    t_entry                        r_rd_q;
    logic                          r_p2_v;
    logic [LW-1:0]                 r_p2_loss;
    logic [lwba_pkg::W_W-1:0]      r_p2_w;
    logic                          r_p3_v;
    logic [lwba_pkg::PROD_W-1:0]   r_p3_prod;
    logic [NUM_W-1:0]              r_num;
    logic [DEN_W-1:0]              r_den;
    logic [NUM_W-1:0]              r_td;

    // result
    lwba_pkg::t_cause              r_cause;
    logic                          r_out_valid;
    logic [KW-1:0]                 r_out_kbps;
    logic                          r_out_chg;
    lwba_pkg::t_cause              r_out_cause;

    t_entry                        ent;
    logic [NW-1:0]                 age;
    logic                          keep;
    logic [lwba_pkg::W_W-1:0]      weight;
    logic                          rd_en;
    logic [NW-1:0]                 since;
    logic [16:0]                   hold_fill;
    logic [lwba_pkg::MUL_W-1:0]    mul;
    logic [lwba_pkg::DIVIDEND_W-1:0] dividend;
    logic                          div_busy;
    logic [lwba_pkg::QUOT_W-1:0]   quot;
    logic [lwba_pkg::QUOT_W-1:0]   q_lo;
    logic [KW-1:0]                 clamped;

    // entry under evaluation: stored entry or the new report
    always_comb begin
        ent       = r_p1_new ? t_entry'{stamp: r_now, loss: r_loss} : r_rd_q;
        age       = r_now - ent.stamp;
        keep      = (age <= NW'(i_cfg.expiry_ms));
        if (ent.loss == '0) begin
            weight = lwba_pkg::W_ZERO_LOSS;
        end else if (age >= NW'(lwba_pkg::W_FULL)) begin
            weight = '0;
        end else begin
            weight = lwba_pkg::W_FULL - age[lwba_pkg::W_W-1:0];
        end
    end

    assign rd_en = r_issue && (r_rd_ptr < r_count);

    always_comb begin
        since     = r_now - r_restart;
        hold_fill = {1'b0, i_cfg.hold_ms} + {1'b0, i_cfg.fill_ms};
    end

    always_comb begin
        o_stat.is_remb   = r_mode;
        o_stat.remb_hit  = (r_code == lwba_pkg::REMB_DEC_CODE) ||
                           (r_code == lwba_pkg::REMB_INC_CODE);
        o_stat.remb_up   = (r_code == lwba_pkg::REMB_INC_CODE);
        o_stat.ignore    = (since < NW'(i_cfg.hold_ms)) ||
                           (r_jitter > i_cfg.jitter_limit_ms);
        o_stat.walk_done = !r_issue && !r_p1_v && !r_p2_v && !r_p3_v;
        o_stat.in_fill   = (since < NW'(hold_fill));
        o_stat.cut       = (r_num >= r_td) && (r_loss != '0);
        o_stat.div_busy  = div_busy;
        o_stat.out_busy  = r_out_valid && !i_tready;
    end

    // scale factor for the shared divider
    always_comb begin
        unique case (i_cmd.div_sel)
            lwba_pkg::CAUSE_CLAMP:    mul = lwba_pkg::UNIT_MUL;
            lwba_pkg::CAUSE_LOSS_CUT:
                mul = (r_loss >= lwba_pkg::CUT_SCALE) ? '0 : lwba_pkg::CUT_SCALE - r_loss;
            lwba_pkg::CAUSE_REMB_DN:  mul = lwba_pkg::REMB_DN_MUL;
            lwba_pkg::CAUSE_REMB_UP:  mul = lwba_pkg::REMB_UP_MUL;
        endcase
        dividend = lwba_pkg::DIVIDEND_W'(r_cur) * lwba_pkg::DIVIDEND_W'(mul);
    end

    lwba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_sel      (i_cmd.div_sel),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    // min first, then max
    always_comb begin
        q_lo    = (quot < lwba_pkg::QUOT_W'(i_cfg.min_kbps)) ?
                  lwba_pkg::QUOT_W'(i_cfg.min_kbps) : quot;
        clamped = (q_lo > lwba_pkg::QUOT_W'(i_cfg.max_kbps)) ?
                  i_cfg.max_kbps : q_lo[KW-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= lwba_pkg::START_KBPS_RST;
            r_restart   <= '0;
            r_count     <= '0;
            r_issue     <= 1'b0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_p1_v      <= 1'b0;
            r_p1_new    <= 1'b0;
            r_p2_v      <= 1'b0;
            r_p3_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.walk_start) begin
                // a full history drops its oldest entry
                r_rd_ptr <= (r_count >= DEPTH_C) ? CNT_W'(1) : '0;
                r_wr_ptr <= '0;
                r_issue  <= 1'b1;
                r_p1_v   <= 1'b0;
            end else begin
                r_p1_v <= r_issue;
                if (r_issue) begin
                    if (r_rd_ptr < r_count) begin
                        r_p1_new <= 1'b0;
                        r_rd_ptr <= r_rd_ptr + 1'b1;
                    end else begin
                        r_p1_new <= 1'b1;
                        r_issue  <= 1'b0;
                    end
                end
                if (r_p1_v && keep) begin
                    r_wr_ptr <= r_wr_ptr + 1'b1;
                end
            end
            r_p2_v <= r_p1_v && keep;
            r_p3_v <= r_p2_v;

            if (i_cmd.walk_end) begin
                r_count <= r_wr_ptr;
            end
            if (i_cmd.cut_commit) begin
                r_count   <= '0;
                r_restart <= r_now;
            end

            if (i_start_load) begin
                r_cur <= i_cfg.start_kbps;
            end else if (i_cmd.emit) begin
                r_cur <= clamped;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_tuser;
            r_now    <= i_tdata[31:0];
            r_loss   <= i_tdata[45:32];
            r_jitter <= i_tdata[61:46];
            r_code   <= i_tdata[79:62];
        end
        if (r_p1_v && keep) begin
            mem[r_wr_ptr[ADDR_W-1:0]] <= ent;
        end
        if (rd_en) begin
            r_rd_q <= mem[r_rd_ptr[ADDR_W-1:0]];
        end
        r_p2_loss <= ent.loss;
        r_p2_w    <= weight;
        r_p3_prod <= lwba_pkg::PROD_W'(r_p2_loss) * lwba_pkg::PROD_W'(r_p2_w);
        if (i_cmd.walk_start) begin
            r_num <= '0;
            r_den <= '0;
        end else begin
            if (r_p2_v) begin
                r_den <= r_den + DEN_W'(r_p2_w);
            end
            if (r_p3_v) begin
                r_num <= r_num + NUM_W'(r_p3_prod);
            end
        end
        r_td <= NUM_W'(i_cfg.loss_trigger) * NUM_W'(r_den);
        if (i_cmd.div_start) begin
            r_cause <= i_cmd.div_sel;
        end
        if (i_cmd.emit) begin
            r_out_kbps  <= clamped;
            r_out_chg   <= (clamped != r_cur);
            r_out_cause <= r_cause;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {7'b0, r_out_chg, r_out_kbps};
    assign o_tuser  = r_out_cause;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("history count above depth");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_v && keep) |-> (r_wr_ptr < DEPTH_C))
        else $error("compaction write beyond history depth");

    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && (i_cfg.min_kbps <= i_cfg.max_kbps)) |=>
        ((r_out_kbps >= $past(i_cfg.min_kbps)) && (r_out_kbps <= $past(i_cfg.max_kbps))))
        else $error("emitted rate outside configured range");

endmodule

`default_nettype wire

/* rtl/loss_weighted_bitrate_adapter.sv */
// A REMB word with a matching code is divided and emitted; a loss report that
// is not ignored walks the history (15 stored entries at most, plus the report),
// is evaluated and, outside the fill window, divided and emitted. One item at a
// time: s_axis_tready is high only while idle. The history walk reads one entry
// per cycle through one memory port; the rate divider is a reciprocal multiply.
// Reset (synchronous, active low): register defaults, 800 kbps, empty history.
`default_nettype none

module loss_weighted_bitrate_adapter #(
    parameter int HISTORY_DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lwba_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [lwba_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // now_ms[31:0], loss[45:32], jitter_ms[61:46], remb_code[79:62]
    input  wire logic [lwba_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // mode[0]
    input  wire logic [0:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // new_kbps[15:0], rate_changed[16], zero[23:17]
    output logic [lwba_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // cause[1:0]
    output logic [1:0]                             m_axis_tuser
);

    lwba_pkg::t_cfg  cfg;
    logic            start_load;
    lwba_pkg::t_cmd  cmd;
    lwba_pkg::t_stat stat;

    lwba_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_cfg        (cfg),
        .o_start_load (start_load)
    );

    lwba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    lwba_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_start_load (start_load),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_tdata      (s_axis_tdata),
        .i_tuser      (s_axis_tuser[0]),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tuser      (m_axis_tuser)
    );

endmodule

`default_nettype wire
